FILE: design/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants of the modexp character cipher
// Control word carried along the cell chain, cell kinds, cipher constants.
// ----------------------------------------------------------------------------
package rmc_pkg;

  // what each cell of the chain does
  typedef enum logic [1:0] {
    CELL_REDUCE,
    CELL_SQUARE,
    CELL_MULT
  } cell_kind_e;

  // control that travels with each word through the chain
  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } ctl_t;

  localparam logic [7:0] CHAR_OFFSET = 8'd55;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [7:0] ASCII_CASE_DIFF = 8'h20;
  localparam logic [1:0] PUBLIC_EXPONENT = 2'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_PRIV_EXP = 1'b1;

endpackage

FILE: design/rmc_cell.sv
// ----------------------------------------------------------------------------
// rmc_cell: one shift-and-add modular multiply step
// Doubles the running product mod n and adds the multiplicand when the
// selected multiplier bit is set; the final cell of a multiply commits it.
// ----------------------------------------------------------------------------
module rmc_cell #(
  parameter int WORD_BITS = 16,
  parameter rmc_pkg::cell_kind_e KIND = rmc_pkg::CELL_SQUARE,
  parameter int MUL_BIT = 0,
  parameter int EXP_BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WORD_BITS-1:0] modulus_i,
  input  rmc_pkg::ctl_t        ctl_i,
  input  logic [WORD_BITS-1:0] exp_i,
  input  logic [WORD_BITS-1:0] base_i,
  input  logic [WORD_BITS-1:0] acc_i,
  input  logic [WORD_BITS-1:0] mac_i,
  output rmc_pkg::ctl_t        ctl_o,
  output logic [WORD_BITS-1:0] exp_o,
  output logic [WORD_BITS-1:0] base_o,
  output logic [WORD_BITS-1:0] acc_o,
  output logic [WORD_BITS-1:0] mac_o
);
  import rmc_pkg::*;

  localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS-1:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  ctl_t                 ctl_q;
  logic [WORD_BITS-1:0] exp_q, base_q, acc_q, mac_q;
  logic [WORD_BITS-1:0] base_d, acc_d, mac_d;
  logic [WORD_BITS-1:0] mcand, mplier, dbl, step;

  always_comb begin
    mcand  = (KIND == CELL_REDUCE) ? ONE : acc_i;
    mplier = (KIND == CELL_SQUARE) ? acc_i : base_i;
    dbl    = add_mod(mac_i, mac_i, modulus_i);
    step   = mplier[MUL_BIT] ? add_mod(dbl, mcand, modulus_i) : dbl;
    base_d = base_i;
    acc_d  = acc_i;
    mac_d  = step;
    if (MUL_BIT == 0) begin
      mac_d = '0;
      unique case (KIND)
        CELL_REDUCE: base_d = step;
        CELL_SQUARE: acc_d = step;
        CELL_MULT:   acc_d = exp_i[EXP_BIT] ? step : acc_i;
        default:     acc_d = acc_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_i;
    base_q <= base_d;
    acc_q  <= acc_d;
    mac_q  <= mac_d;
  end

  assign ctl_o  = ctl_q;
  assign exp_o  = exp_q;
  assign base_o = base_q;
  assign acc_o  = acc_q;
  assign mac_o  = mac_q;

endmodule

FILE: design/rsa_modexp_char_cipher.sv
// ----------------------------------------------------------------------------
// rsa_modexp_char_cipher: textbook RSA cipher, one word per cycle
// Encrypts characters (cube mod n) or decrypts values (power d mod n).
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is taken at a clock edge with start_i high and busy_o low.
//   busy_o stays low, so a new word may follow every cycle.
//   Output: done_o marks result_o / last_out_o for one cycle; the receiver
//   cannot stall, and words leave in the order they came in.
//   Config: cfg_valid_i / cfg_ready_o write cfg_data_i into register
//   cfg_index_i (0 modulus, 1 private exponent); cfg_ready_o is always high.
//   Write config only while no word is in flight.
// Path: an input register, the chain of multiply cells and an output register
//   lie between accept and done_o. The chain holds the multiply cells:
//   WORD_BITS cells reduce the base, then each exponent bit takes
//   WORD_BITS cells to square and WORD_BITS cells to multiply.
// Throughput: one word per cycle.
// Reset: the chain empties and the registers go to modulus 55, exponent 27.
// ----------------------------------------------------------------------------
module rsa_modexp_char_cipher #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 op_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic                 last_in_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] result_o,
  output logic                 last_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [WORD_BITS-1:0] cfg_data_i
);
  import rmc_pkg::*;

  localparam int NCELL = WORD_BITS + 2 * WORD_BITS * WORD_BITS;

  logic [WORD_BITS-1:0] modulus_q, priv_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WORD_BITS'(55);
      priv_exp_q <= WORD_BITS'(27);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODULUS:  modulus_q <= cfg_data_i;
        CFG_PRIV_EXP: priv_exp_q <= cfg_data_i;
        default:      modulus_q <= modulus_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // input preparation
  logic [7:0]           ch, ch_up;
  logic [WORD_BITS-1:0] x_d, exp_d;
  ctl_t                 ctl_d;

  always_comb begin
    ch    = value_i[7:0];
    ch_up = (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) ? ch - ASCII_CASE_DIFF : ch;
    ctl_d.valid = start_i && !busy_o;
    ctl_d.last  = last_in_i;
    ctl_d.zero  = (modulus_q < WORD_BITS'(2));
    if (op_i == OP_ENCRYPT) begin
      x_d   = WORD_BITS'(ch_up - CHAR_OFFSET);
      exp_d = WORD_BITS'(PUBLIC_EXPONENT);
      if (ch_up < CHAR_OFFSET) ctl_d.zero = 1'b1;
    end else begin
      x_d   = value_i;
      exp_d = priv_exp_q;
    end
  end

  ctl_t                 ctl_w  [NCELL+1];
  logic [WORD_BITS-1:0] exp_w  [NCELL+1];
  logic [WORD_BITS-1:0] base_w [NCELL+1];
  logic [WORD_BITS-1:0] acc_w  [NCELL+1];
  logic [WORD_BITS-1:0] mac_w  [NCELL+1];

  ctl_t                 prep_ctl_q;
  logic [WORD_BITS-1:0] prep_exp_q, prep_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_ctl_q <= '0;
    end else begin
      prep_ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_exp_q <= exp_d;
    prep_x_q   <= x_d;
  end

  assign ctl_w[0]  = prep_ctl_q;
  assign exp_w[0]  = prep_exp_q;
  assign base_w[0] = prep_x_q;
  assign acc_w[0]  = WORD_BITS'(1);
  assign mac_w[0]  = '0;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    localparam int R = (c < WORD_BITS) ? 0 : c - WORD_BITS;
    localparam int S = R % (2 * WORD_BITS);
    localparam cell_kind_e KIND = (c < WORD_BITS) ? CELL_REDUCE :
                                  (S < WORD_BITS) ? CELL_SQUARE : CELL_MULT;
    localparam int MUL_BIT = (c < WORD_BITS) ? WORD_BITS - 1 - c
                                             : WORD_BITS - 1 - (S % WORD_BITS);
    localparam int EXP_BIT = WORD_BITS - 1 - (R / (2 * WORD_BITS));
    rmc_cell #(
      .WORD_BITS(WORD_BITS),
      .KIND     (KIND),
      .MUL_BIT  (MUL_BIT),
      .EXP_BIT  (EXP_BIT)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .modulus_i(modulus_q),
      .ctl_i    (ctl_w[c]),
      .exp_i    (exp_w[c]),
      .base_i   (base_w[c]),
      .acc_i    (acc_w[c]),
      .mac_i    (mac_w[c]),
      .ctl_o    (ctl_w[c+1]),
      .exp_o    (exp_w[c+1]),
      .base_o   (base_w[c+1]),
      .acc_o    (acc_w[c+1]),
      .mac_o    (mac_w[c+1])
    );
  end

  // output register
  logic                 done_q, last_q;
  logic [WORD_BITS-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_w[NCELL].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= ctl_w[NCELL].last;
    result_q <= ctl_w[NCELL].zero ? '0 : acc_w[NCELL];
  end

  assign done_o     = done_q;
  assign result_o   = result_q;
  assign last_out_o = last_q;

endmodule

FILE: design/rmc_checker.sv
// ----------------------------------------------------------------------------
// rmc_checker: port-level checks of the modexp character cipher
// Latency, marker ordering, the below-offset character case and busy_o low.
// ----------------------------------------------------------------------------
module rmc_checker #(
  parameter int WORD_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 op_i,
  input logic [WORD_BITS-1:0] value_i,
  input logic                 last_in_i,
  input logic                 done_o,
  input logic [WORD_BITS-1:0] result_o,
  input logic                 last_out_o
);
  import rmc_pkg::*;

  localparam int LAT = WORD_BITS + 2 * WORD_BITS * WORD_BITS + 2;

  // every result traces back to an accepted input word
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without matching input word");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> last_out_o == $past(last_in_i, LAT))
    else $error("last marker out of order");

  // characters below the offset encrypt to zero
  a_low_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(op_i == OP_ENCRYPT && value_i[7:0] < CHAR_OFFSET, LAT))
      |-> result_o == '0)
    else $error("low character not zero");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

endmodule

bind rsa_modexp_char_cipher rmc_checker #(.WORD_BITS(WORD_BITS)) u_rmc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .op_i      (op_i),
  .value_i   (value_i),
  .last_in_i (last_in_i),
  .done_o    (done_o),
  .result_o  (result_o),
  .last_out_o(last_out_o)
);

FILE: tb/rsa_modexp_char_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modexp_char_cipher_test: self-checking bench for the RSA char cipher
// Drives encrypt/decrypt words under several key settings, predicts each
// result with exact modular arithmetic and checks results in order.
// ----------------------------------------------------------------------------
module rsa_modexp_char_cipher_test;
  import rmc_pkg::*;

  localparam int WB = 16;
  localparam int LATENCY = WB + 2 * WB * WB + 2;
  localparam int STALL_LIMIT = 20 * LATENCY;

  typedef struct packed {
    logic [WB-1:0] result;
    logic          last;
  } cipher_word_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  class cipher_scoreboard;
    logic [WB-1:0] modulus = 16'd55;
    logic [WB-1:0] priv_exp = 16'd27;
    cipher_word_t pending[$];

    function automatic logic [WB-1:0] power_mod(logic [WB-1:0] base, logic [WB-1:0] e);
      longint unsigned acc, b, m;
      m = modulus;
      acc = 1 % m;
      b = base % m;
      for (int i = WB - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * b) % m;
      end
      return acc[WB-1:0];
    endfunction

    function void note_input(logic op, logic [WB-1:0] value, logic last);
      cipher_word_t w;
      logic [7:0] c;
      w.result = '0;
      w.last = last;
      if (modulus >= 2) begin
        if (op == OP_ENCRYPT) begin
          c = value[7:0];
          if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) c = c - ASCII_CASE_DIFF;
          if (c >= CHAR_OFFSET) w.result = power_mod(WB'(c - CHAR_OFFSET), WB'(PUBLIC_EXPONENT));
        end else begin
          w.result = power_mod(value, priv_exp);
        end
      end
      pending.push_back(w);
    endfunction

    task check_result(logic [WB-1:0] result, logic last);
      cipher_word_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", result, 0);
      end else begin
        w = pending.pop_front();
        if (result !== w.result) report_mismatch("result", result, w.result);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0, op_i = 0, last_in_i = 0;
  logic [WB-1:0] value_i = '0;
  logic busy_o, done_o, last_out_o, cfg_ready_o;
  logic [WB-1:0] result_o;
  logic cfg_valid_i = 0, cfg_index_i = 0;
  logic [WB-1:0] cfg_data_i = '0;

  cipher_scoreboard sb = new();
  int idle_pct = 17;
  int quiet_cycles = 0;

  rsa_modexp_char_cipher #(.WORD_BITS(WB)) DUT (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (done_o) sb.check_result(result_o, last_out_o);
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [WB-1:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MODULUS) sb.modulus = data;
    else sb.priv_exp = data;
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic op, input logic [WB-1:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    op_i <= op;
    value_i <= value;
    last_in_i <= last;
    do @(posedge clk_i); while (busy_o);
    sb.note_input(op, value, last);
  endtask

  task automatic drain;
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic random_words(input int n);
    logic [WB-1:0] v;
    for (int i = 0; i < n; i++) begin
      idle_pct = (i % 250 < 60) ? 0 : 17;
      if ($urandom_range(1)) begin
        v = $urandom_range(9) < 7 && sb.modulus != 0 ? WB'($urandom_range(sb.modulus - 1))
                                                      : WB'($urandom);
        send_word(OP_DECRYPT, v, $urandom_range(1));
      end else begin
        v = $urandom_range(3) == 0 ? WB'($urandom) : WB'($urandom_range(8'h7f, 8'h20));
        send_word(OP_ENCRYPT, v, $urandom_range(1));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: reset key, char edges, case folding, high byte
    send_word(OP_ENCRYPT, 16'h0041, 0);
    send_word(OP_ENCRYPT, 16'h0061, 1);
    send_word(OP_ENCRYPT, 16'h007a, 0);
    send_word(OP_ENCRYPT, 16'h007b, 0);
    send_word(OP_ENCRYPT, 16'h0036, 1);
    send_word(OP_ENCRYPT, 16'h0037, 0);
    send_word(OP_ENCRYPT, 16'hff00, 0);
    send_word(OP_ENCRYPT, 16'hffff, 1);
    send_word(OP_DECRYPT, 16'd0, 0);
    send_word(OP_DECRYPT, 16'd54, 0);
    send_word(OP_DECRYPT, 16'd55, 1);
    send_word(OP_DECRYPT, 16'hffff, 0);
    drain();
    write_reg(CFG_PRIV_EXP, 16'd0);
    send_word(OP_DECRYPT, 16'd7, 1);
    drain();
    write_reg(CFG_MODULUS, 16'd0);
    send_word(OP_DECRYPT, 16'd7, 0);
    send_word(OP_ENCRYPT, 16'h005a, 1);
    drain();
    write_reg(CFG_MODULUS, 16'd1);
    send_word(OP_DECRYPT, 16'd7, 0);
    send_word(OP_ENCRYPT, 16'h005a, 1);
    drain();
    write_reg(CFG_MODULUS, 16'hffff);
    write_reg(CFG_PRIV_EXP, 16'hffff);
    send_word(OP_DECRYPT, 16'hfffe, 0);
    send_word(OP_ENCRYPT, 16'h00ff, 1);
    drain();
    // random phases over several keys, extremes included
    write_reg(CFG_MODULUS, 16'd3233);
    write_reg(CFG_PRIV_EXP, 16'd2011);
    random_words(500);
    drain();
    write_reg(CFG_MODULUS, 16'hffff);
    write_reg(CFG_PRIV_EXP, 16'hffff);
    random_words(400);
    drain();
    write_reg(CFG_MODULUS, 16'd2);
    write_reg(CFG_PRIV_EXP, 16'd1);
    random_words(200);
    drain();
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_MODULUS, WB'($urandom));
      write_reg(CFG_PRIV_EXP, WB'($urandom));
      random_words(300);
      drain();
    end
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
design/rmc_pkg.sv
design/rmc_cell.sv
design/rsa_modexp_char_cipher.sv
design/rmc_checker.sv
tb/rsa_modexp_char_cipher_test.sv
